/* sv/gsv_pkg.sv */
`timescale 1ns / 1ps
// gsv_pkg: widths, vertex-mask codes, register indexes and shared types
// for the grid strip vertex generator. No dependencies.
package gsv_pkg;

  localparam int PIECES_MAX = 4096;
  localparam int FRAC_BITS  = 16;

  localparam int CNT_W  = 13;   // piece counts and corner indices
  localparam int IDX_W  = 12;   // cell column / row
  localparam int POS_W  = 31;
  localparam int TEX_W  = 32;
  localparam int NKIND  = 6;    // vertex kinds a cell can emit
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_PIECES_X     = 3'd0;
  localparam logic [2:0] REG_PIECES_Y     = 3'd1;
  localparam logic [2:0] REG_STEP_X       = 3'd2;
  localparam logic [2:0] REG_STEP_Y       = 3'd3;
  localparam logic [2:0] REG_TEX_STEP_S   = 3'd4;
  localparam logic [2:0] REG_TEX_STEP_T   = 3'd5;
  localparam logic [2:0] REG_TEX_ORIGIN_S = 3'd6;
  localparam logic [2:0] REG_TEX_ORIGIN_T = 3'd7;

  // Vertex mask bits, in emission order
  localparam int VK_LEAD_B  = 0;
  localparam int VK_B       = 1;
  localparam int VK_A       = 2;
  localparam int VK_D       = 3;
  localparam int VK_C       = 4;
  localparam int VK_TRAIL_C = 5;

  // Kinds that sit one column right / one row down
  localparam logic [NKIND-1:0] KIND_DI = (NKIND'(1) << VK_D) | (NKIND'(1) << VK_C) |
                                         (NKIND'(1) << VK_TRAIL_C);
  localparam logic [NKIND-1:0] KIND_DJ = (NKIND'(1) << VK_LEAD_B) | (NKIND'(1) << VK_B) |
                                         (NKIND'(1) << VK_D);

  typedef logic [NKIND-1:0] vmask_t;

  typedef struct packed {
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    vmask_t           mask;
  } cell_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic        [CNT_W-1:0] pieces_x;
    logic        [CNT_W-1:0] pieces_y;
    logic        [POS_W-1:0] step_x;
    logic        [POS_W-1:0] step_y;
    logic signed [TEX_W-1:0] tex_step_s;
    logic signed [TEX_W-1:0] tex_step_t;
    logic signed [TEX_W-1:0] tex_origin_s;
    logic signed [TEX_W-1:0] tex_origin_t;
  } cfg_t;

endpackage

/* sv/grid_strip_vertex_generator_unit.sv */
`timescale 1ns / 1ps
// grid_strip_vertex_generator_unit: top level with the register file,
// cell classifier, cell queue and vertex back end. Depends on gsv_pkg.
//
//   Channel   Handshake                    Payload
//   -------   --------------------------   ------------------------------------
//   cell in   start & !busy                in_cell_col, in_cell_row
//   vertex    out_valid (one cycle each)   out_pos_x/y, out_tex_s/t,
//                                          out_last_of_cell
//   regs      psel & penable & pwrite      paddr (4*index), pwdata, prdata
//
// Vertices: each cell yields 2 to 6 vertices, one per clock at the result port,
// 2 for an interior cell and more on the first and last columns; the back-end
// sequencer emits them. Between leaving the queue and the port, a vertex passes
// the sequencer register, the corner-index stage, the product stage and the
// output register; an accepted cell first passes the queue.
// Stalls: busy is high only while the 4-entry cell queue is full. The
// receiver cannot stall; vertices are never held.
// Reset: synchronous, active low; registers return to their reset values
// and the queue and pipeline are emptied.
module grid_strip_vertex_generator_unit import gsv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // cell transactions
  input  logic                    start,
  output logic                    busy,
  input  logic        [IDX_W-1:0] in_cell_col,
  input  logic        [IDX_W-1:0] in_cell_row,
  // vertex transactions
  output logic                    out_valid,
  output logic        [POS_W-1:0] out_pos_x,
  output logic        [POS_W-1:0] out_pos_y,
  output logic signed [TEX_W-1:0] out_tex_s,
  output logic signed [TEX_W-1:0] out_tex_t,
  output logic                    out_last_of_cell,
  // register port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic              [4:0] paddr,
  input  logic             [31:0] pwdata,
  output logic             [31:0] prdata,
  output logic                    pready
);

  cfg_t       cfg_r;
  logic [2:0] reg_idx;
  logic       reg_wr;

  cell_t      cls_cell;
  cell_t      q_head;
  q_stat_t    q_stat;
  logic       q_push;
  logic       q_pop;

  // ---------------- register file ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pieces_x     <= CNT_W'(1);
      cfg_r.pieces_y     <= CNT_W'(1);
      cfg_r.step_x       <= POS_W'(1) << FRAC_BITS;
      cfg_r.step_y       <= POS_W'(1) << FRAC_BITS;
      cfg_r.tex_step_s   <= TEX_W'(1) << FRAC_BITS;
      cfg_r.tex_step_t   <= TEX_W'(1) << FRAC_BITS;
      cfg_r.tex_origin_s <= '0;
      cfg_r.tex_origin_t <= '0;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_PIECES_X:     cfg_r.pieces_x     <= pwdata[CNT_W-1:0];
        REG_PIECES_Y:     cfg_r.pieces_y     <= pwdata[CNT_W-1:0];
        REG_STEP_X:       cfg_r.step_x       <= pwdata[POS_W-1:0];
        REG_STEP_Y:       cfg_r.step_y       <= pwdata[POS_W-1:0];
        REG_TEX_STEP_S:   cfg_r.tex_step_s   <= pwdata;
        REG_TEX_STEP_T:   cfg_r.tex_step_t   <= pwdata;
        REG_TEX_ORIGIN_S: cfg_r.tex_origin_s <= pwdata;
        REG_TEX_ORIGIN_T: cfg_r.tex_origin_t <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PIECES_X:     prdata = 32'(cfg_r.pieces_x);
      REG_PIECES_Y:     prdata = 32'(cfg_r.pieces_y);
      REG_STEP_X:       prdata = 32'(cfg_r.step_x);
      REG_STEP_Y:       prdata = 32'(cfg_r.step_y);
      REG_TEX_STEP_S:   prdata = cfg_r.tex_step_s;
      REG_TEX_STEP_T:   prdata = cfg_r.tex_step_t;
      REG_TEX_ORIGIN_S: prdata = cfg_r.tex_origin_s;
      REG_TEX_ORIGIN_T: prdata = cfg_r.tex_origin_t;
      default:          prdata = '0;
    endcase
  end

  // ---------------- front: classify and enqueue ----------------
  assign busy   = q_stat.full;
  assign q_push = start && !busy;

  gsv_front u_front (
    .cell_col (in_cell_col),
    .cell_row (in_cell_row),
    .cfg      (cfg_r),
    .cell_cls (cls_cell)
  );

  gsv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cell (cls_cell),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  // ---------------- back: sequence vertices and compute ----------------
  gsv_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .head  (q_head),
    .qstat (q_stat),
    .pop   (q_pop),
    .vld   (out_valid),
    .pos_x (out_pos_x),
    .pos_y (out_pos_y),
    .tex_s (out_tex_s),
    .tex_t (out_tex_t),
    .last  (out_last_of_cell)
  );

endmodule

/* sv/gsv_front.sv */
`timescale 1ns / 1ps
// gsv_front: classifies an incoming cell into the set of strip vertices it
// emits. Depends on gsv_pkg.
module gsv_front import gsv_pkg::*; (
  input  logic [IDX_W-1:0] cell_col,
  input  logic [IDX_W-1:0] cell_row,
  input  cfg_t             cfg,
  output cell_t            cell_cls
);

  logic [CNT_W-1:0] px_eff;
  logic [CNT_W-1:0] py_eff;
  logic [CNT_W-1:0] col_p1;
  logic [CNT_W-1:0] row_p1;
  logic             multi_row;
  logic             first_col;

  always_comb begin
    px_eff    = (cfg.pieces_x > CNT_W'(PIECES_MAX)) ? CNT_W'(PIECES_MAX) : cfg.pieces_x;
    py_eff    = (cfg.pieces_y > CNT_W'(PIECES_MAX)) ? CNT_W'(PIECES_MAX) : cfg.pieces_y;
    col_p1    = CNT_W'(cell_col) + CNT_W'(1);
    row_p1    = CNT_W'(cell_row) + CNT_W'(1);
    multi_row = py_eff > CNT_W'(1);
    first_col = (cell_col == '0);

    cell_cls.col  = cell_col;
    cell_cls.row  = cell_row;
    cell_cls.mask = '0;
    cell_cls.mask[VK_LEAD_B]  = multi_row && first_col && (cell_row != '0);
    cell_cls.mask[VK_B]       = first_col;
    cell_cls.mask[VK_A]       = first_col;
    cell_cls.mask[VK_D]       = 1'b1;
    cell_cls.mask[VK_C]       = 1'b1;
    cell_cls.mask[VK_TRAIL_C] = multi_row && (col_p1 == px_eff) && (row_p1 != py_eff);
  end

endmodule

/* sv/gsv_queue.sv */
`timescale 1ns / 1ps
// gsv_queue: small FIFO of classified cells between front and back.
// Depends on gsv_pkg.
module gsv_queue import gsv_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cell_t   push_cell,
  input  logic    pop,
  output cell_t   head,
  output q_stat_t stat
);

  cell_t               mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cell;
    end
  end

  assign head       = mem[rd_ptr_r];
  assign stat.full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

/* sv/gsv_back.sv */
`timescale 1ns / 1ps
// gsv_back: walks each cell's vertex mask one vertex per cycle, then a
// corner-index, a multiply and a saturating add stage. Depends on gsv_pkg.
module gsv_back import gsv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  cell_t                   head,
  input  q_stat_t                 qstat,
  output logic                    pop,
  output logic                    vld,
  output logic        [POS_W-1:0] pos_x,
  output logic        [POS_W-1:0] pos_y,
  output logic signed [TEX_W-1:0] tex_s,
  output logic signed [TEX_W-1:0] tex_t,
  output logic                    last
);

  localparam int PP_W = CNT_W + POS_W;       // position product
  localparam int TP_W = CNT_W + 1 + TEX_W;   // texture product, signed
  localparam int TS_W = TP_W + 1;            // texture sum

  function automatic logic [POS_W-1:0] sat_pos(input logic [PP_W-1:0] v);
    return (v[PP_W-1:POS_W] != '0) ? {POS_W{1'b1}} : v[POS_W-1:0];
  endfunction

  function automatic logic signed [TEX_W-1:0] sat_tex(input logic signed [TS_W-1:0] v);
    logic hi_same;
    hi_same = (v[TS_W-1:TEX_W-1] == '0) || (v[TS_W-1:TEX_W-1] == '1);
    if (hi_same) return v[TEX_W-1:0];
    return v[TS_W-1] ? {1'b1, {(TEX_W-1){1'b0}}} : {1'b0, {(TEX_W-1){1'b1}}};
  endfunction

  // sequencer: current cell and the vertices still to emit
  logic [IDX_W-1:0] col_r, row_r;
  vmask_t           rem_r, rem_nxt;
  vmask_t           low;
  vmask_t           left;

  // stage 1: corner indices
  logic             s1_vld_r;
  logic             s1_last_r;
  logic [CNT_W-1:0] s1_i_r, s1_j_r;

  // stage 2: products
  logic                   s2_vld_r;
  logic                   s2_last_r;
  logic [PP_W-1:0]        px_prod_r, py_prod_r;
  logic signed [TP_W-1:0] ts_prod_r, tt_prod_r;
  logic [PP_W-1:0]        px_prod_nxt, py_prod_nxt;
  logic signed [TP_W-1:0] ts_prod_nxt, tt_prod_nxt;
  logic signed [TS_W-1:0] ts_sum, tt_sum;

  always_comb begin
    low  = rem_r & (~rem_r + vmask_t'(1));
    left = rem_r & ~low;
    pop  = (left == '0) && !qstat.empty;
    if (pop) begin
      rem_nxt = head.mask;
    end else begin
      rem_nxt = left;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r    <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      vld      <= 1'b0;
    end else begin
      rem_r    <= rem_nxt;
      s1_vld_r <= (rem_r != '0);
      s2_vld_r <= s1_vld_r;
      vld      <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      col_r <= head.col;
      row_r <= head.row;
    end
    s1_i_r    <= CNT_W'(col_r) + CNT_W'(|(low & KIND_DI));
    s1_j_r    <= CNT_W'(row_r) + CNT_W'(|(low & KIND_DJ));
    s1_last_r <= (left == '0);
  end

  always_comb begin
    px_prod_nxt = PP_W'(s1_i_r) * PP_W'(cfg.step_x);
    py_prod_nxt = PP_W'(s1_j_r) * PP_W'(cfg.step_y);
    ts_prod_nxt = TP_W'($signed({1'b0, s1_i_r})) * TP_W'($signed(cfg.tex_step_s));
    tt_prod_nxt = TP_W'($signed({1'b0, s1_j_r})) * TP_W'($signed(cfg.tex_step_t));
  end

  always_ff @(posedge clk) begin
    px_prod_r <= px_prod_nxt;
    py_prod_r <= py_prod_nxt;
    ts_prod_r <= ts_prod_nxt;
    tt_prod_r <= tt_prod_nxt;
    s2_last_r <= s1_last_r;
  end

  always_comb begin
    ts_sum = TS_W'(ts_prod_r) + TS_W'($signed(cfg.tex_origin_s));
    tt_sum = TS_W'(tt_prod_r) + TS_W'($signed(cfg.tex_origin_t));
  end

  always_ff @(posedge clk) begin
    pos_x <= sat_pos(px_prod_r);
    pos_y <= sat_pos(py_prod_r);
    tex_s <= sat_tex(ts_sum);
    tex_t <= sat_tex(tt_sum);
    last  <= s2_last_r;
  end

endmodule

/* tb/grid_strip_vertex_generator_unit_tb.sv */
`timescale 1ns / 1ps
// grid_strip_vertex_generator_unit_tb: self-checking bench for the grid strip vertex generator.
// Drives cells and APB register writes, predicts every strip vertex, compares. Needs gsv_pkg.
module grid_strip_vertex_generator_unit_tb;
  import gsv_pkg::*;

  localparam int SETTLE_CYCLES = 6;     // covers the queue-to-vertex path, plus margin
  localparam int DRAIN_LIMIT   = 2000;  // cycles to wait for outstanding vertices
  localparam int RAND_PHASES   = 6;
  localparam int PHASE_CELLS   = 21;
  localparam int DIR_ROWS      = 43;

  // One strip vertex as seen on the result port
  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [TEX_W-1:0] tex_s;
    logic [TEX_W-1:0] tex_t;
    logic             last;
  } vertex_t;

  typedef enum bit {ROW_REG, ROW_CELL} row_kind_t;

  // Directed row: a register write or a cell. Cell rows with known set carry the final
  // vertex of the cell typed in by hand; reg_idx and data are unused on cell rows.
  typedef struct packed {
    row_kind_t        kind;
    logic [2:0]       reg_idx;
    logic [31:0]      data;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    bit               known;
    logic [POS_W-1:0] k_pos_x;
    logic [POS_W-1:0] k_pos_y;
    logic [TEX_W-1:0] k_tex_s;
    logic [TEX_W-1:0] k_tex_t;
  } dir_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic        [IDX_W-1:0] in_cell_col = '0;
  logic        [IDX_W-1:0] in_cell_row = '0;
  logic                    out_valid;
  logic        [POS_W-1:0] out_pos_x;
  logic        [POS_W-1:0] out_pos_y;
  logic signed [TEX_W-1:0] out_tex_s;
  logic signed [TEX_W-1:0] out_tex_t;
  logic                    out_last_of_cell;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic              [4:0] paddr = '0;
  logic             [31:0] pwdata = '0;
  logic             [31:0] prdata;
  logic                    pready;

  cfg_t    plate_cfg;            // bench copy of the register file
  vertex_t pending_vertices[$];  // vertices predicted but not yet seen
  int      fail_count = 0;
  int      vertices_seen = 0;
  int      idle_pct = 0;         // sender idle chance per transaction, percent

  grid_strip_vertex_generator_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cell_col      (in_cell_col),
    .in_cell_row      (in_cell_row),
    .out_valid        (out_valid),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_tex_s        (out_tex_s),
    .out_tex_t        (out_tex_t),
    .out_last_of_cell (out_last_of_cell),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #6 clk = ~clk;

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Directed table: reset values first, then a 4x3 grid with fractional and
  // flipped steps, then zero and over-range piece counts, then saturation.
  dir_row_t dir_tab [0:DIR_ROWS-1] = '{
    // reset config: 1x1 plate, unit steps
    '{ROW_CELL, REG_PIECES_X, 32'h0, 12'd0, 12'd0, 1'b1,
      31'h10000, 31'h0, 32'h10000, 32'h0},
    '{ROW_CELL, REG_PIECES_X, 32'h0, 12'd1, 12'd0, 1'b1,
      31'h20000, 31'h0, 32'h20000, 32'h0},
    '{ROW_CELL, REG_PIECES_X, 32'h0, 12'd4095, 12'd4095, 1'b1,
      31'h10000000, 31'h0FFF0000, 32'h10000000, 32'h0FFF0000},
    // 4x3 grid, s flipped
    '{ROW_REG, REG_PIECES_X,     32'd4,          12'd0, 12'd0, 1'b0, '0, '0, '0, '0},
    '{ROW_REG, REG_PIECES_Y,     32'd3,          12'd0, 12'd0, 1'b0, '0, '0, '0, '0},
    '{ROW_REG, REG_STEP_X,       32'h0001_8000,  12'd0, 12'd0, 1'b0, '0, '0, '0, '0},
    '{ROW_REG, REG_STEP_Y,       32'h0000_8000,  12'd0, 12'd0, 1'b0, '0, '0, '0, '0},
    '{ROW_REG, REG_TEX_STEP_S,   32'hFFFF_C000,  12'd0, 12'd0, 1'b0, '0, '0, '0, '0},
    '{ROW_REG, REG_TEX_STEP_T,   32'h0000_4000,  12'd0, 12'd0, 1'b0, '0, '0, '0, '0},
    '{ROW_REG, REG_TEX_ORIGIN_S, 32'hFFFF_8000,  12'd0, 12'd0, 1'b0, '0, '0, '0, '0},
    '{ROW_REG, REG_TEX_ORIGIN_T, 32'h0002_4000,  12'd0, 12'd0, 1'b0, '0, '0, '0, '0},
    '{ROW_CELL, REG_PIECES_X, 32'h0, 12'd0, 12'd0, 1'b0, '0, '0, '0, '0},
    '{ROW_CELL, REG_PIECES_X, 32'h0, 12'd1, 12'd0, 1'b0, '0, '0, '0, '0},
    '{ROW_CELL, REG_PIECES_X, 32'h0, 12'd3, 12'd0, 1'b0, '0, '0, '0, '0},  // trailing C
    '{ROW_CELL, REG_PIECES_X, 32'h0, 12'd0, 12'd1, 1'b0, '0, '0, '0, '0},  // leading B
    '{ROW_CELL, REG_PIECES_X, 32'h0, 12'd3, 12'd1, 1'b0, '0, '0, '0, '0},
    '{ROW_CELL, REG_PIECES_X, 32'h0, 12'd0, 12'd2, 1'b0, '0, '0, '0, '0},
    '{ROW_CELL, REG_PIECES_X, 32'h0, 12'd2, 12'd2, 1'b0, '0, '0, '0, '0},
    '{ROW_CELL, REG_PIECES_X, 32'h0, 12'd3, 12'd2, 1'b0, '0, '0, '0, '0},  // last row, no trailing C
    '{ROW_CELL, REG_PIECES_X, 32'h0, 12'd6, 12'd5, 1'b0, '0, '0, '0, '0},  // off the grid
    '{ROW_CELL, REG_PIECES_X, 32'h0, 12'd3, 12'd7, 1'b0, '0, '0, '0, '0},  // row past the end
    // zero piece counts
    '{ROW_REG, REG_PIECES_Y,     32'd0,          12'd0, 12'd0, 1'b0, '0, '0, '0, '0},
    '{ROW_CELL, REG_PIECES_X, 32'h0, 12'd0, 12'd2, 1'b0, '0, '0, '0, '0},
    '{ROW_REG, REG_PIECES_X,     32'd0,          12'd0, 12'd0, 1'b0, '0, '0, '0, '0},
    '{ROW_REG, REG_PIECES_Y,     32'd2,          12'd0, 12'd0, 1'b0, '0, '0, '0, '0},
    '{ROW_CELL, REG_PIECES_X, 32'h0, 12'd4095, 12'd0, 1'b0, '0, '0, '0, '0},
    // counts above the maximum clamp to 4096
    '{ROW_REG, REG_PIECES_X,     32'd8191,       12'd0, 12'd0, 1'b0, '0, '0, '0, '0},
    '{ROW_CELL, REG_PIECES_X, 32'h0, 12'd4095, 12'd0, 1'b0, '0, '0, '0, '0},
    '{ROW_REG, REG_PIECES_Y,     32'd8191,       12'd0, 12'd0, 1'b0, '0, '0, '0, '0},
    '{ROW_CELL, REG_PIECES_X, 32'h0, 12'd4095, 12'd4095, 1'b0, '0, '0, '0, '0},
    '{ROW_CELL, REG_PIECES_X, 32'h0, 12'd0, 12'd4095, 1'b0, '0, '0, '0, '0},
    // saturation on every output
    '{ROW_REG, REG_STEP_X,       32'h7FFF_FFFF,  12'd0, 12'd0, 1'b0, '0, '0, '0, '0},
    '{ROW_REG, REG_STEP_Y,       32'h7FFF_FFFF,  12'd0, 12'd0, 1'b0, '0, '0, '0, '0},
    '{ROW_REG, REG_TEX_STEP_S,   32'h7FFF_FFFF,  12'd0, 12'd0, 1'b0, '0, '0, '0, '0},
    '{ROW_REG, REG_TEX_STEP_T,   32'h8000_0000,  12'd0, 12'd0, 1'b0, '0, '0, '0, '0},
    '{ROW_REG, REG_TEX_ORIGIN_S, 32'h7FFF_FFFF,  12'd0, 12'd0, 1'b0, '0, '0, '0, '0},
    '{ROW_REG, REG_TEX_ORIGIN_T, 32'h8000_0000,  12'd0, 12'd0, 1'b0, '0, '0, '0, '0},
    '{ROW_CELL, REG_PIECES_X, 32'h0, 12'd4095, 12'd4095, 1'b1,
      31'h7FFFFFFF, 31'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000},
    '{ROW_CELL, REG_PIECES_X, 32'h0, 12'd0, 12'd0, 1'b1,
      31'h7FFFFFFF, 31'h0, 32'h7FFFFFFF, 32'h80000000},
    '{ROW_REG, REG_TEX_STEP_S,   32'h8000_0000,  12'd0, 12'd0, 1'b0, '0, '0, '0, '0},
    '{ROW_REG, REG_TEX_ORIGIN_S, 32'h8000_0000,  12'd0, 12'd0, 1'b0, '0, '0, '0, '0},
    '{ROW_REG, REG_STEP_X,       32'h0,          12'd0, 12'd0, 1'b0, '0, '0, '0, '0},
    '{ROW_CELL, REG_PIECES_X, 32'h0, 12'd0, 12'd0, 1'b1,
      31'h0, 31'h0, 32'h80000000, 32'h80000000}
  };

  task automatic log_fail(input string msg);
    fail_count++;
    if (fail_count <= 10)
      $display("ERROR @%0t: %s", $time, msg);
  endtask

  // index * step, clipped to the 31-bit position range
  function automatic logic [POS_W-1:0] sat_pos(input longint idx, input logic [POS_W-1:0] step);
    longint s;
    longint p;
    s = longint'(step);
    p = idx * s;
    return (p > 64'sd2147483647) ? {POS_W{1'b1}} : p[POS_W-1:0];
  endfunction

  // index * step + origin, clipped to the int32 range
  function automatic logic [TEX_W-1:0] sat_tex(input longint idx, input logic [TEX_W-1:0] step,
                                               input logic [TEX_W-1:0] origin);
    longint v;
    v = idx * longint'($signed(step)) + longint'($signed(origin));
    if (v > 64'sd2147483647)
      return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648)
      return 32'h8000_0000;
    return v[TEX_W-1:0];
  endfunction

  function automatic vertex_t corner_vertex(input longint i, input longint j);
    vertex_t v;
    v.pos_x = sat_pos(i, plate_cfg.step_x);
    v.pos_y = sat_pos(j, plate_cfg.step_y);
    v.tex_s = sat_tex(i, plate_cfg.tex_step_s, plate_cfg.tex_origin_s);
    v.tex_t = sat_tex(j, plate_cfg.tex_step_t, plate_cfg.tex_origin_t);
    v.last  = 1'b0;
    return v;
  endfunction

  // Strip vertices of one cell, in emission order: lead B, B, A, D, C, trail C
  task automatic predict_strip(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
    longint c;
    longint r;
    longint px;
    longint py;
    bit     multi_row;
    c  = longint'(col);
    r  = longint'(row);
    px = longint'(plate_cfg.pieces_x);
    py = longint'(plate_cfg.pieces_y);
    if (px > PIECES_MAX) px = PIECES_MAX;
    if (py > PIECES_MAX) py = PIECES_MAX;
    multi_row = (py > 1);
    if (multi_row && c == 0 && r > 0)
      pending_vertices.push_back(corner_vertex(c, r + 1));
    if (c == 0) begin
      pending_vertices.push_back(corner_vertex(c, r + 1));
      pending_vertices.push_back(corner_vertex(c, r));
    end
    pending_vertices.push_back(corner_vertex(c + 1, r + 1));
    pending_vertices.push_back(corner_vertex(c + 1, r));
    if (multi_row && c + 1 == px && r + 1 != py)
      pending_vertices.push_back(corner_vertex(c + 1, r));
    pending_vertices[pending_vertices.size() - 1].last = 1'b1;
  endtask

  // Lower start and wait for every predicted vertex, then let the pipe settle.
  task automatic drain_vertices();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (pending_vertices.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_vertices.size() != 0) begin
      log_fail($sformatf("%0d predicted vertices never arrived", pending_vertices.size()));
      pending_vertices.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write, only with the block idle. Updates the bench copy of the register
  // and reads the register back after the write completes.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
    logic [31:0] readback;
    drain_vertices();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PIECES_X:     plate_cfg.pieces_x     = data[CNT_W-1:0];
      REG_PIECES_Y:     plate_cfg.pieces_y     = data[CNT_W-1:0];
      REG_STEP_X:       plate_cfg.step_x       = data[POS_W-1:0];
      REG_STEP_Y:       plate_cfg.step_y       = data[POS_W-1:0];
      REG_TEX_STEP_S:   plate_cfg.tex_step_s   = data;
      REG_TEX_STEP_T:   plate_cfg.tex_step_t   = data;
      REG_TEX_ORIGIN_S: plate_cfg.tex_origin_s = data;
      REG_TEX_ORIGIN_T: plate_cfg.tex_origin_t = data;
      default: ;
    endcase
    case (idx)
      REG_PIECES_X, REG_PIECES_Y: readback = 32'(data[CNT_W-1:0]);
      REG_STEP_X, REG_STEP_Y:     readback = 32'(data[POS_W-1:0]);
      default:                    readback = data;
    endcase
    @(posedge clk);
    if (prdata !== readback)
      log_fail($sformatf("register %0d read back %h, want %h", idx, prdata, readback));
  endtask

  // One cell transaction: optional idle gap, then hold start until !busy at an edge.
  // start stays high afterwards; the next caller either reloads it or drops it.
  task automatic send_cell(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_cell_col <= col;
    in_cell_row <= row;
    do @(posedge clk); while (busy);
    predict_strip(col, row);
  endtask

  // Result check: values read here are the ones before the edge, so each
  // strobed vertex is taken exactly at the edge that ends its cycle.
  always @(posedge clk) begin : vertex_check
    vertex_t want;
    if (rst_n && out_valid) begin
      vertices_seen++;
      if (pending_vertices.size() == 0) begin
        log_fail($sformatf("vertex %0d arrived with none predicted", vertices_seen));
      end else begin
        want = pending_vertices.pop_front();
        if (out_pos_x !== want.pos_x || out_pos_y !== want.pos_y ||
            out_tex_s !== want.tex_s || out_tex_t !== want.tex_t ||
            out_last_of_cell !== want.last)
          log_fail($sformatf({"vertex %0d: got x=%h y=%h s=%h t=%h last=%b, ",
                              "want x=%h y=%h s=%h t=%h last=%b"}, vertices_seen,
                             out_pos_x, out_pos_y, out_tex_s, out_tex_t, out_last_of_cell,
                             want.pos_x, want.pos_y, want.tex_s, want.tex_t, want.last));
      end
    end
  end

  initial begin : stimulus
    int          idle_plan [RAND_PHASES];
    int          px_eff;
    int          py_eff;
    int          walk_col;
    int          walk_row;
    int          pick;
    logic [2:0]  ridx;
    logic [31:0] rval;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;

    idle_plan = '{0, 59, 23, 0, 59, 23};
    plate_cfg = '{pieces_x: 13'd1, pieces_y: 13'd1,
                  step_x: 31'h10000, step_y: 31'h10000,
                  tex_step_s: 32'h10000, tex_step_t: 32'h10000,
                  tex_origin_s: 32'h0, tex_origin_t: 32'h0};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, no idling
    idle_pct = 0;
    foreach (dir_tab[n]) begin
      if (dir_tab[n].kind == ROW_REG) begin
        reg_write(dir_tab[n].reg_idx, dir_tab[n].data);
      end else begin
        send_cell(dir_tab[n].col, dir_tab[n].row);
        if (dir_tab[n].known)
          pending_vertices[pending_vertices.size() - 1] =
            '{dir_tab[n].k_pos_x, dir_tab[n].k_pos_y, dir_tab[n].k_tex_s,
              dir_tab[n].k_tex_t, 1'b1};
      end
    end

    // Random phases: fresh register set, then mostly raster walks of the grid
    // (the normal use) mixed with random in-grid and full-range cells.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      idle_pct = 0;
      for (int k = 0; k <= REG_TEX_ORIGIN_T; k++) begin
        ridx = k[2:0];
        case (ridx)
          REG_PIECES_X, REG_PIECES_Y: begin
            case ($urandom_range(0, 9))
              0:       rval = 32'd0;
              1:       rval = $urandom;
              2:       rval = PIECES_MAX;
              default: rval = $urandom_range(1, 6);
            endcase
          end
          REG_STEP_X, REG_STEP_Y: begin
            case ($urandom_range(0, 3))
              0:       rval = 32'h7FFF_FFFF;
              1:       rval = $urandom;
              default: rval = $urandom_range(0, 32'h30000);
            endcase
          end
          default: begin
            case ($urandom_range(0, 3))
              0:       rval = $urandom;
              1:       rval = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
              default: rval = $urandom_range(0, 32'h60000) - 32'h30000;
            endcase
          end
        endcase
        reg_write(ridx, rval);
      end

      px_eff = int'(plate_cfg.pieces_x);
      py_eff = int'(plate_cfg.pieces_y);
      if (px_eff > PIECES_MAX) px_eff = PIECES_MAX;
      if (py_eff > PIECES_MAX) py_eff = PIECES_MAX;
      if (px_eff == 0) px_eff = 1;
      if (py_eff == 0) py_eff = 1;
      walk_col = 0;
      walk_row = 0;
      idle_pct = idle_plan[ph];

      for (int n = 0; n < PHASE_CELLS; n++) begin
        // hold off until the block has emptied, at least once per phase
        if (n == PHASE_CELLS / 2 || $urandom_range(0, 29) == 0)
          drain_vertices();
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          col = walk_col[IDX_W-1:0];
          row = walk_row[IDX_W-1:0];
          walk_col++;
          if (walk_col >= px_eff) begin
            walk_col = 0;
            walk_row++;
            if (walk_row >= py_eff) walk_row = 0;
          end
        end else if (pick < 85) begin
          col = IDX_W'($urandom_range(0, px_eff - 1));
          row = IDX_W'($urandom_range(0, py_eff - 1));
        end else begin
          col = IDX_W'($urandom);
          row = IDX_W'($urandom);
        end
        send_cell(col, row);
      end
    end

    drain_vertices();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/gsv_pkg.sv
sv/gsv_front.sv
sv/gsv_queue.sv
sv/gsv_back.sv
sv/grid_strip_vertex_generator_unit.sv
tb/grid_strip_vertex_generator_unit_tb.sv
